// File: hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    // Store geometry.
    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 64;
    localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(CELLS);

    // Field widths.
    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = ATTR_W + CHAR_W;

    // Wide enough for row * width + col and for the cell count itself.
    localparam int ADDR_FULL_W = ((ADDR_W + 1) > (ROW_W + COL_W + 2)) ?
                                 (ADDR_W + 1) : (ROW_W + COL_W + 2);

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_LAST_COLUMN    = 2'd0;
    localparam logic [1:0] REG_LAST_ROW       = 2'd1;
    localparam logic [1:0] REG_TEXT_ATTRIBUTE = 2'd2;

    localparam logic [COL_W-1:0]  LAST_COLUMN_RESET = 7'd79;
    localparam logic [ROW_W-1:0]  LAST_ROW_RESET    = 6'd24;
    localparam logic [ATTR_W-1:0] ATTR_RESET        = 8'h07;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [CELL_W-1:0] RESET_CELL = {ATTR_RESET, CH_SPACE};

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_PUT   = 2'd1,
        MODE_READ  = 2'd2,
        MODE_SET   = 2'd3
    } tcw_mode_t;

    // Outcome of one teletype character.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             store;
        logic             bell;
        logic             scroll;
    } tcw_step_t;

endpackage

// File: hw/rtl/tcw_if.sv
`timescale 1ns / 1ps

interface tcw_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 mode;
    logic [tcw_pkg::CHAR_W-1:0] char_code;
    logic [tcw_pkg::COL_W-1:0]  target_col;
    logic [tcw_pkg::ROW_W-1:0]  target_row;

    modport source (output valid, mode, char_code, target_col, target_row, input ready);
    modport sink   (input valid, mode, char_code, target_col, target_row, output ready);
endinterface

interface tcw_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [tcw_pkg::COL_W-1:0]  cursor_col;
    logic [tcw_pkg::ROW_W-1:0]  cursor_row;
    logic                       bell;
    logic                       scrolled;
    logic [tcw_pkg::CELL_W-1:0] cell_word;

    modport source (output valid, cursor_col, cursor_row, bell, scrolled, cell_word,
                    input ready);
    modport sink   (input valid, cursor_col, cursor_row, bell, scrolled, cell_word,
                    output ready);
endinterface

// File: hw/rtl/tcw_cursor_step.sv
`timescale 1ns / 1ps

module tcw_cursor_step (
    input  logic [tcw_pkg::COL_W-1:0]  col,
    input  logic [tcw_pkg::ROW_W-1:0]  row,
    input  logic [tcw_pkg::CHAR_W-1:0] ch,
    input  logic [tcw_pkg::COL_W-1:0]  lc,
    input  logic [tcw_pkg::ROW_W-1:0]  lr,
    output tcw_pkg::tcw_step_t         step
);

    // One extra bit each: the column may run one past 127 and the row may pass 63.
    logic [tcw_pkg::COL_W:0] col_w;
    logic [tcw_pkg::ROW_W:0] row_w;

    always_comb
    begin
        col_w       = {1'b0, col};
        row_w       = {1'b0, row};
        step.store  = 1'b0;
        step.bell   = 1'b0;
        step.scroll = 1'b0;

        case (ch)
            tcw_pkg::CH_LF:
            begin
                row_w = row_w + 1'b1;
            end
            tcw_pkg::CH_CR:
            begin
                col_w = '0;
            end
            tcw_pkg::CH_BS:
            begin
                if (col != '0)
                begin
                    col_w = col_w - 1'b1;
                end
                else if (row != '0)
                begin
                    row_w = row_w - 1'b1;
                    col_w = {1'b0, lc};
                end
            end
            tcw_pkg::CH_BEL:
            begin
                step.bell = 1'b1;
            end
            default:
            begin
                step.store = 1'b1;
                col_w      = col_w + 1'b1;
            end
        endcase

        if (col_w > {1'b0, lc})
        begin
            col_w = '0;
            row_w = row_w + 1'b1;
        end

        // Only one scroll per character, even if the row was far below the screen.
        if (row_w > {1'b0, lr})
        begin
            step.scroll = 1'b1;
            row_w       = row_w - 1'b1;
        end

        step.col = col_w[tcw_pkg::COL_W-1:0];
        step.row = row_w[tcw_pkg::ROW_W-1:0];
    end

endmodule

// File: hw/rtl/text_console_char_writer.sv
`timescale 1ns / 1ps
// Text console character writer.
// Commands arrive as beats on cmd (mode, char_code, target_col, target_row) and each
// produces exactly one result beat on rsp (cursor, bell, scrolled, cell_word).
// The screen lives in a 16-bit cell memory with a registered read port; the
// cursor and the three APB registers sit in flops. APB registers must be written
// only while no command is in flight; the block itself does not enforce this.
// After reset the block clears every cell to a space with attribute 7, one cell
// per cycle; cmd.ready stays low meanwhile, APB writes still work.
// The block takes one command at a time, as cmd.ready is high only while idle.
// A read goes through the memory read, then the data return, before its result.
// A scroll is a read-and-write sweep over the screen, one cell per cycle, that
// copies each cell one row up and fills the bottom row with blanks.
// The result sits in an output register: the next command is accepted while a
// result still waits on a stalled rsp, and the block then holds its next result
// until the register frees up.
module text_console_char_writer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    tcw_cmd_if.sink                      cmd,
    tcw_rsp_if.source                    rsp
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    localparam int AW = tcw_pkg::ADDR_FULL_W;

    state_t state_reg, state_next;

    logic [tcw_pkg::COL_W-1:0]  last_column_reg, last_column_next;
    logic [tcw_pkg::ROW_W-1:0]  last_row_reg, last_row_next;
    logic [tcw_pkg::ATTR_W-1:0] text_attribute_reg, text_attribute_next;

    logic [tcw_pkg::COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [tcw_pkg::ROW_W-1:0]  cur_row_reg, cur_row_next;

    tcw_pkg::tcw_mode_t         mode_reg, mode_next;
    logic [tcw_pkg::CHAR_W-1:0] char_reg, char_next;
    logic [tcw_pkg::COL_W-1:0]  tcol_reg, tcol_next;
    logic [tcw_pkg::ROW_W-1:0]  trow_reg, trow_next;

    logic [tcw_pkg::ADDR_W-1:0] clr_idx_reg, clr_idx_next;
    logic [AW-1:0]              scr_idx_reg, scr_idx_next;
    logic [AW-1:0]              moved_reg, moved_next;
    logic [AW-1:0]              total_reg, total_next;

    logic                       pipe_valid_reg, pipe_valid_next;
    logic [tcw_pkg::ADDR_W-1:0] pipe_addr_reg, pipe_addr_next;
    logic                       pipe_fill_reg, pipe_fill_next;

    logic                       rd_oob_reg, rd_oob_next;
    logic                       res_bell_reg, res_bell_next;
    logic                       res_scrolled_reg, res_scrolled_next;
    logic [tcw_pkg::CELL_W-1:0] res_word_reg, res_word_next;

    logic                       out_valid_reg, out_valid_next;
    logic [tcw_pkg::COL_W-1:0]  out_col_reg, out_col_next;
    logic [tcw_pkg::ROW_W-1:0]  out_row_reg, out_row_next;
    logic                       out_bell_reg, out_bell_next;
    logic                       out_scrolled_reg, out_scrolled_next;
    logic [tcw_pkg::CELL_W-1:0] out_word_reg, out_word_next;

    // Cell memory.
    logic [tcw_pkg::CELL_W-1:0] cell_mem [tcw_pkg::CELLS];
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;
    logic                       mem_we;
    logic [tcw_pkg::ADDR_W-1:0] mem_waddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [tcw_pkg::ADDR_W-1:0] mem_raddr;

    logic [tcw_pkg::COL_W-1:0]  eff_col;
    logic [tcw_pkg::ROW_W-1:0]  eff_row;
    logic [tcw_pkg::COL_W:0]    width;
    logic [tcw_pkg::COL_W-1:0]  addr_col;
    logic [tcw_pkg::ROW_W-1:0]  addr_row;
    logic [AW-1:0]              addr_full;
    logic                       addr_ok;
    logic [AW-1:0]              scr_src;
    logic [tcw_pkg::CELL_W-1:0] fill_cell;
    logic                       apb_wr;
    logic                       out_free;
    logic                       go_finish;

    tcw_pkg::tcw_step_t         step;

    tcw_cursor_step u_step (
        .col  (cur_col_reg),
        .row  (cur_row_reg),
        .ch   (char_reg),
        .lc   (eff_col),
        .lr   (eff_row),
        .step (step)
    );

    always_comb
    begin
        eff_col = last_column_reg;
        if (int'(last_column_reg) > tcw_pkg::MAX_COLUMNS - 1)
        begin
            eff_col = tcw_pkg::COL_W'(tcw_pkg::MAX_COLUMNS - 1);
        end
        eff_row = last_row_reg;
        if (int'(last_row_reg) > tcw_pkg::MAX_ROWS - 1)
        begin
            eff_row = tcw_pkg::ROW_W'(tcw_pkg::MAX_ROWS - 1);
        end
    end

    assign width     = {1'b0, eff_col} + 1'b1;
    assign fill_cell = {text_attribute_reg, tcw_pkg::CH_SPACE};

    // A read addresses the target cell, every other mode the cursor cell.
    assign addr_col  = (mode_reg == tcw_pkg::MODE_READ) ? tcol_reg : cur_col_reg;
    assign addr_row  = (mode_reg == tcw_pkg::MODE_READ) ? trow_reg : cur_row_reg;
    assign addr_full = AW'(addr_row) * AW'(width) + AW'(addr_col);
    assign addr_ok   = addr_full < AW'(tcw_pkg::CELLS);
    assign scr_src   = scr_idx_reg + AW'(width);

    assign apb_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        case (paddr[3:2])
            tcw_pkg::REG_LAST_COLUMN:    prdata = tcw_pkg::PDATA_W'(last_column_reg);
            tcw_pkg::REG_LAST_ROW:       prdata = tcw_pkg::PDATA_W'(last_row_reg);
            tcw_pkg::REG_TEXT_ATTRIBUTE: prdata = tcw_pkg::PDATA_W'(text_attribute_reg);
            default:                     prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next          = state_reg;
        last_column_next    = last_column_reg;
        last_row_next       = last_row_reg;
        text_attribute_next = text_attribute_reg;
        cur_col_next        = cur_col_reg;
        cur_row_next        = cur_row_reg;
        mode_next           = mode_reg;
        char_next           = char_reg;
        tcol_next           = tcol_reg;
        trow_next           = trow_reg;
        clr_idx_next        = clr_idx_reg;
        scr_idx_next        = scr_idx_reg;
        // Scroll geometry follows the registers; it is settled long before use.
        moved_next          = AW'(width) * AW'(eff_row);
        total_next          = moved_reg + AW'(width);
        pipe_valid_next     = 1'b0;
        pipe_addr_next      = pipe_addr_reg;
        pipe_fill_next      = pipe_fill_reg;
        rd_oob_next         = rd_oob_reg;
        res_bell_next       = res_bell_reg;
        res_scrolled_next   = res_scrolled_reg;
        res_word_next       = res_word_reg;
        out_valid_next      = out_valid_reg;
        out_col_next        = out_col_reg;
        out_row_next        = out_row_reg;
        out_bell_next       = out_bell_reg;
        out_scrolled_next   = out_scrolled_reg;
        out_word_next       = out_word_reg;
        mem_we              = 1'b0;
        mem_waddr           = pipe_addr_reg;
        mem_wdata           = pipe_fill_reg ? fill_cell : rd_data_reg;
        mem_re              = 1'b0;
        mem_raddr           = scr_src[tcw_pkg::ADDR_W-1:0];
        go_finish           = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (apb_wr)
        begin
            case (paddr[3:2])
                tcw_pkg::REG_LAST_COLUMN:    last_column_next    = pwdata[tcw_pkg::COL_W-1:0];
                tcw_pkg::REG_LAST_ROW:       last_row_next       = pwdata[tcw_pkg::ROW_W-1:0];
                tcw_pkg::REG_TEXT_ATTRIBUTE: text_attribute_next = pwdata[tcw_pkg::ATTR_W-1:0];
                default:                     ;
            endcase
        end

        // Second half of the scroll copy: the cell read last cycle lands one row up.
        if (pipe_valid_reg)
        begin
            mem_we = 1'b1;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = tcw_pkg::RESET_CELL;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    mode_next  = tcw_pkg::tcw_mode_t'(cmd.mode);
                    char_next  = cmd.char_code;
                    tcol_next  = cmd.target_col;
                    trow_next  = cmd.target_row;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_bell_next     = 1'b0;
                res_scrolled_next = 1'b0;
                res_word_next     = '0;
                mem_waddr         = addr_full[tcw_pkg::ADDR_W-1:0];
                mem_wdata         = {text_attribute_reg, char_reg};
                case (mode_reg)
                    tcw_pkg::MODE_WRITE:
                    begin
                        cur_col_next      = step.col;
                        cur_row_next      = step.row;
                        res_bell_next     = step.bell;
                        res_scrolled_next = step.scroll;
                        mem_we            = step.store && addr_ok;
                        if (step.scroll)
                        begin
                            scr_idx_next = '0;
                            state_next   = ST_SCROLL;
                        end
                        else
                        begin
                            go_finish = 1'b1;
                        end
                    end
                    tcw_pkg::MODE_PUT:
                    begin
                        mem_we    = addr_ok;
                        go_finish = 1'b1;
                    end
                    tcw_pkg::MODE_READ:
                    begin
                        mem_re      = addr_ok;
                        mem_raddr   = addr_full[tcw_pkg::ADDR_W-1:0];
                        rd_oob_next = !addr_ok;
                        state_next  = ST_READ;
                    end
                    default:
                    begin
                        cur_col_next = tcol_reg;
                        cur_row_next = trow_reg;
                        go_finish    = 1'b1;
                    end
                endcase
            end
            ST_READ:
            begin
                res_word_next = rd_oob_reg ? '0 : rd_data_reg;
                state_next    = ST_FINISH;
            end
            ST_SCROLL:
            begin
                mem_re          = scr_idx_reg < moved_reg;
                pipe_valid_next = 1'b1;
                pipe_addr_next  = scr_idx_reg[tcw_pkg::ADDR_W-1:0];
                pipe_fill_next  = scr_idx_reg >= moved_reg;
                scr_idx_next    = scr_idx_reg + 1'b1;
                if (scr_idx_next == total_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                go_finish = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (go_finish)
        begin
            if (out_free)
            begin
                out_valid_next    = 1'b1;
                out_col_next      = cur_col_next;
                out_row_next      = cur_row_next;
                out_bell_next     = res_bell_next;
                out_scrolled_next = res_scrolled_next;
                out_word_next     = res_word_next;
                state_next        = ST_IDLE;
            end
            else
            begin
                state_next = ST_FINISH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            last_column_reg    <= tcw_pkg::LAST_COLUMN_RESET;
            last_row_reg       <= tcw_pkg::LAST_ROW_RESET;
            text_attribute_reg <= tcw_pkg::ATTR_RESET;
            cur_col_reg        <= '0;
            cur_row_reg        <= '0;
            mode_reg           <= tcw_pkg::MODE_WRITE;
            char_reg           <= '0;
            tcol_reg           <= '0;
            trow_reg           <= '0;
            clr_idx_reg        <= '0;
            scr_idx_reg        <= '0;
            moved_reg          <= '0;
            total_reg          <= '0;
            pipe_valid_reg     <= 1'b0;
            pipe_addr_reg      <= '0;
            pipe_fill_reg      <= 1'b0;
            rd_oob_reg         <= 1'b0;
            res_bell_reg       <= 1'b0;
            res_scrolled_reg   <= 1'b0;
            res_word_reg       <= '0;
            out_valid_reg      <= 1'b0;
            out_col_reg        <= '0;
            out_row_reg        <= '0;
            out_bell_reg       <= 1'b0;
            out_scrolled_reg   <= 1'b0;
            out_word_reg       <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            last_column_reg    <= last_column_next;
            last_row_reg       <= last_row_next;
            text_attribute_reg <= text_attribute_next;
            cur_col_reg        <= cur_col_next;
            cur_row_reg        <= cur_row_next;
            mode_reg           <= mode_next;
            char_reg           <= char_next;
            tcol_reg           <= tcol_next;
            trow_reg           <= trow_next;
            clr_idx_reg        <= clr_idx_next;
            scr_idx_reg        <= scr_idx_next;
            moved_reg          <= moved_next;
            total_reg          <= total_next;
            pipe_valid_reg     <= pipe_valid_next;
            pipe_addr_reg      <= pipe_addr_next;
            pipe_fill_reg      <= pipe_fill_next;
            rd_oob_reg         <= rd_oob_next;
            res_bell_reg       <= res_bell_next;
            res_scrolled_reg   <= res_scrolled_next;
            res_word_reg       <= res_word_next;
            out_valid_reg      <= out_valid_next;
            out_col_reg        <= out_col_next;
            out_row_reg        <= out_row_next;
            out_bell_reg       <= out_bell_next;
            out_scrolled_reg   <= out_scrolled_next;
            out_word_reg       <= out_word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= cell_mem[mem_raddr];
        end
    end

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.cursor_col = out_col_reg;
    assign rsp.cursor_row = out_row_reg;
    assign rsp.bell       = out_bell_reg;
    assign rsp.scrolled   = out_scrolled_reg;
    assign rsp.cell_word  = out_word_reg;

endmodule

// File: hw/rtl/tcw_checker.sv
`timescale 1ns / 1ps

module tcw_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_valid,
    input logic                       cmd_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [tcw_pkg::COL_W-1:0]  rsp_cursor_col,
    input logic [tcw_pkg::ROW_W-1:0]  rsp_cursor_row,
    input logic                       rsp_bell,
    input logic                       rsp_scrolled,
    input logic [tcw_pkg::CELL_W-1:0] rsp_cell_word
);

    // One command at a time: cmd.ready drops as soon as a beat is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("cmd.ready high right after an accepted beat");

    // Bell and scroll come only from teletype writes, which never return a cell.
    a_word_zero_on_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_bell || rsp_scrolled) |-> rsp_cell_word == '0)
        else $error("cell_word nonzero on a bell or scroll result");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_col) &&
            $stable(rsp_cursor_row) && $stable(rsp_bell) && $stable(rsp_scrolled) &&
            $stable(rsp_cell_word))
        else $error("stalled rsp beat changed");

endmodule

bind text_console_char_writer tcw_checker u_tcw_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_cursor_col (rsp.cursor_col),
    .rsp_cursor_row (rsp.cursor_row),
    .rsp_bell       (rsp.bell),
    .rsp_scrolled   (rsp.scrolled),
    .rsp_cell_word  (rsp.cell_word)
);
